[hdl/bkrs_pkg.sv]
`timescale 1ns / 1ps
// bkrs_pkg: shared types and constants of the byte key radix sorter.
// No dependencies; used by the interfaces, controller, datapath and top level.
package bkrs_pkg;

    localparam int KEY_W       = 8;
    localparam int TAG_W       = 16;
    localparam int DIGIT_W     = 4;
    localparam int NUM_BUCKETS = 16;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_COUNT,
        ST_CDRAIN,
        ST_PREFIX,
        ST_SCATTER,
        ST_SDRAIN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // input channel open
        logic idx_clr;   // read index back to zero
        logic idx_inc;   // advance read index
        logic bkt_clr;   // clear buckets, running total, prefix step
        logic cnt_rd;    // read for the counting pass
        logic pfx_en;    // one prefix-sum step
        logic sct_rd;    // read for the scatter pass
        logic pass;      // 0: low digit A->B, 1: high digit B->A
        logic emit_ld;   // load output register
        logic set_done;  // clear loaded count and drop flag
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_acc;  // word marked last accepted
        logic idx_last;  // read index is at the final record
        logic pfx_last;  // prefix step on the final bucket
        logic out_free;  // output register can take a word
    } t_sts;

endpackage

[hdl/bkrs_in_if.sv]
`timescale 1ns / 1ps
// bkrs_in_if: record input channel, valid/ready with key, tag and last.
// Depends on bkrs_pkg.
interface bkrs_in_if;
    logic                        valid;
    logic                        ready;
    logic [bkrs_pkg::KEY_W-1:0]  key;
    logic [bkrs_pkg::TAG_W-1:0]  tag;
    logic                        last;

    modport source (output valid, output key, output tag, output last, input ready);
    modport sink   (input valid, input key, input tag, input last, output ready);
endinterface

[hdl/bkrs_out_if.sv]
`timescale 1ns / 1ps
// bkrs_out_if: sorted result channel, valid/ready with key, tag and set flags.
// Depends on bkrs_pkg.
interface bkrs_out_if;
    logic                        valid;
    logic                        ready;
    logic [bkrs_pkg::KEY_W-1:0]  sorted_key;
    logic [bkrs_pkg::TAG_W-1:0]  sorted_tag;
    logic                        end_of_set;
    logic                        overflow;

    modport source (output valid, output sorted_key, output sorted_tag,
                    output end_of_set, output overflow, input ready);
    modport sink   (input valid, input sorted_key, input sorted_tag,
                    input end_of_set, input overflow, output ready);
endinterface

[hdl/bkrs_ram.sv]
`timescale 1ns / 1ps
// bkrs_ram: generic simple dual-port RAM, one write port, registered read.
// No dependencies.
module bkrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/bkrs_datapath.sv]
`timescale 1ns / 1ps
// bkrs_datapath: record buffers A and B, bucket counters, index and output register.
// Depends on bkrs_pkg, bkrs_in_if, bkrs_out_if and bkrs_ram.
module bkrs_datapath #(
    parameter int MAX_RECORDS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bkrs_pkg::t_cmd  i_cmd,
    output bkrs_pkg::t_sts  o_sts,
    bkrs_in_if.sink         i_rec,
    bkrs_out_if.source      o_res
);
    import bkrs_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_drop, n_drop;
    logic [AW-1:0]      r_idx, n_idx;
    logic [DIGIT_W-1:0] r_pj, n_pj;
    logic [CW-1:0]      r_tot, n_tot;
    logic [CW-1:0]      r_bkt [NUM_BUCKETS];
    logic [CW-1:0]      n_bkt [NUM_BUCKETS];
    logic               r_cnt_dv, r_sct_dv;

    logic               r_ovld, n_ovld;
    logic [KEY_W-1:0]   r_okey;
    logic [TAG_W-1:0]   r_otag;
    logic               r_oeos, r_oovf;

    logic               accept, store;
    t_rec               a_rd, b_rd, src, in_rec;
    logic               a_we, b_we;
    logic [AW-1:0]      a_waddr;
    t_rec               a_wdata;
    logic [DIGIT_W-1:0] digit, bidx;
    logic [CW-1:0]      pos;

    // Input handshake and store-full check
    assign i_rec.ready = i_cmd.load;
    assign accept      = i_rec.valid & i_rec.ready;
    assign store       = accept && (r_cnt < CW'(MAX_RECORDS));
    assign in_rec      = '{key: i_rec.key, tag: i_rec.tag};

    // Source buffer and digit for the current pass
    assign src   = i_cmd.pass ? b_rd : a_rd;
    assign digit = i_cmd.pass ? src.key[2*DIGIT_W-1:DIGIT_W] : src.key[DIGIT_W-1:0];
    assign bidx  = i_cmd.pfx_en ? r_pj : digit;
    assign pos   = r_bkt[bidx];

    // Buffer A: loaded from input, written by the high-digit scatter
    assign a_we    = store | (r_sct_dv & i_cmd.pass);
    assign a_waddr = r_sct_dv ? pos[AW-1:0] : r_cnt[AW-1:0];
    assign a_wdata = r_sct_dv ? src : in_rec;
    assign b_we    = r_sct_dv & ~i_cmd.pass;

    bkrs_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_RECORDS)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (a_we),
        .i_wr_addr (a_waddr),
        .i_wr_data (a_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (a_rd)
    );

    bkrs_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_RECORDS)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (b_we),
        .i_wr_addr (pos[AW-1:0]),
        .i_wr_data (src),
        .i_rd_addr (r_idx),
        .o_rd_data (b_rd)
    );

    // Set bookkeeping and read index
    always_comb begin
        n_cnt  = r_cnt;
        n_drop = r_drop;
        n_idx  = r_idx;
        if (i_cmd.set_done) begin
            n_cnt  = '0;
            n_drop = 1'b0;
        end else if (store) begin
            n_cnt = r_cnt + CW'(1);
        end else if (accept) begin
            n_drop = 1'b1;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // Buckets: count, prefix sum to start offsets, then bump per scattered word
    always_comb begin
        n_bkt = r_bkt;
        n_tot = r_tot;
        n_pj  = r_pj;
        if (i_cmd.bkt_clr) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                n_bkt[b] = '0;
            end
            n_tot = '0;
            n_pj  = '0;
        end else if (i_cmd.pfx_en) begin
            n_bkt[bidx] = r_tot;
            n_tot       = r_tot + pos;
            n_pj        = r_pj + DIGIT_W'(1);
        end else if (r_cnt_dv || r_sct_dv) begin
            n_bkt[bidx] = pos + CW'(1);
        end
    end

    // Output register
    always_comb begin
        n_ovld = r_ovld;
        if (i_cmd.emit_ld) begin
            n_ovld = 1'b1;
        end else if (o_res.ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
            r_cnt_dv <= 1'b0;
            r_sct_dv <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_idx    <= n_idx;
            r_cnt_dv <= i_cmd.cnt_rd;
            r_sct_dv <= i_cmd.sct_rd;
            r_ovld   <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bkt <= n_bkt;
        r_tot <= n_tot;
        r_pj  <= n_pj;
        if (i_cmd.emit_ld) begin
            r_okey <= a_rd.key;
            r_otag <= a_rd.tag;
            r_oeos <= o_sts.idx_last;
            r_oovf <= r_drop;
        end
    end

    assign o_res.valid      = r_ovld;
    assign o_res.sorted_key = r_okey;
    assign o_res.sorted_tag = r_otag;
    assign o_res.end_of_set = r_oeos;
    assign o_res.overflow   = r_oovf;

    // Status to the controller
    assign o_sts.last_acc = accept & i_rec.last;
    assign o_sts.idx_last = (CW'(r_idx) + CW'(1)) == r_cnt;
    assign o_sts.pfx_last = &r_pj;
    assign o_sts.out_free = ~r_ovld | o_res.ready;

    // Checks
    a_pos_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sct_dv |-> (pos < r_cnt))
        else $error("scatter offset beyond loaded set");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RECORDS))
        else $error("loaded count above capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_ld |-> o_sts.out_free)
        else $error("output register overwritten");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_ld && o_sts.idx_last) |=> ((r_cnt == '0) && !r_drop))
        else $error("set state not cleared after final word");

    a_bkt_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_dv || r_sct_dv) |-> !i_cmd.pfx_en)
        else $error("bucket update collides with prefix step");

endmodule

[hdl/bkrs_ctrl.sv]
`timescale 1ns / 1ps
// bkrs_ctrl: sequencer for load, two radix passes and emit.
// Depends on bkrs_pkg.
module bkrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bkrs_pkg::t_sts  i_sts,
    output bkrs_pkg::t_cmd  o_cmd
);
    import bkrs_pkg::*;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.last_acc) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.bkt_clr = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state       = ST_COUNT;
            end
            ST_COUNT: begin
                o_cmd.cnt_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_CDRAIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CDRAIN: begin
                // last count update lands here
                o_cmd.idx_clr = 1'b1;
                n_state       = ST_PREFIX;
            end
            ST_PREFIX: begin
                o_cmd.pfx_en = 1'b1;
                if (i_sts.pfx_last) begin
                    n_state = ST_SCATTER;
                end
            end
            ST_SCATTER: begin
                o_cmd.sct_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_SDRAIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_SDRAIN: begin
                o_cmd.idx_clr = 1'b1;
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = ST_INIT;
                end else begin
                    n_pass  = 1'b0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                // buffer A read at the index, data next cycle
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.set_done = 1'b1;
                        n_state        = ST_LOAD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

[hdl/byte_key_radix_sorter.sv]
`timescale 1ns / 1ps
// byte_key_radix_sorter: top level, controller plus datapath.
// Depends on bkrs_pkg, bkrs_in_if, bkrs_out_if, bkrs_ctrl and bkrs_datapath.
//
// Records (8-bit key, 16-bit tag) load one word per cycle into buffer A. The
// word marked last closes the set; the block then stops taking input and sorts
// by ascending key with a stable two-pass radix sort on 4-bit digits, each pass
// a count over the set, a 16-step prefix sum and a scatter into the other
// buffer, and finally emits the records in order, end_of_set on the final one.
// The sort is paced by the single read port of each record buffer, and emitting
// reads each record from buffer A and loads it into the output register, held by
// any output stall; input reopens right after the final word is registered.
// Records arriving with MAX_RECORDS already loaded are dropped, and overflow is
// then set in every result word of that set.
module byte_key_radix_sorter #(
    parameter int MAX_RECORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bkrs_in_if.sink     i_rec,
    bkrs_out_if.source  o_res
);
    import bkrs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bkrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bkrs_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_rec   (i_rec),
        .o_res   (o_res)
    );

endmodule

[tb/byte_key_radix_sorter_test.sv]
`timescale 1ns / 1ps
// byte_key_radix_sorter_test: self-checking bench for the byte key radix sorter.
// Depends on bkrs_pkg, bkrs_in_if, bkrs_out_if and byte_key_radix_sorter.
module byte_key_radix_sorter_test;
    import bkrs_pkg::*;

    localparam int CAPACITY = 64;
    localparam int KEY_VALUES = 1 << KEY_W;
    localparam int RANDOM_WORDS = 200;
    localparam int DIRECTED_ROWS = 19;

    // One sorted output word as the bench expects it
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             eos;
        logic             ovf;
    } t_sorted_word;

    // Directed row: the record, and the sorted word where it is plain to see
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             typed;
        t_sorted_word     want;
    } t_stim_row;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // lone records right after reset, both extremes
        '{8'h00, 16'h0000, 1'b1, 1'b1, '{8'h00, 16'h0000, 1'b1, 1'b0}},
        '{8'hFF, 16'hFFFF, 1'b1, 1'b1, '{8'hFF, 16'hFFFF, 1'b1, 1'b0}},
        // high digit decides over low digit
        '{8'h21, 16'h0001, 1'b0, 1'b0, '0},
        '{8'h12, 16'h0002, 1'b0, 1'b0, '0},
        '{8'h22, 16'h0003, 1'b0, 1'b0, '0},
        '{8'h11, 16'h0004, 1'b1, 1'b0, '0},
        // equal keys keep arrival order
        '{8'h5A, 16'h1111, 1'b0, 1'b0, '0},
        '{8'h5A, 16'h2222, 1'b0, 1'b0, '0},
        '{8'h00, 16'hFFFF, 1'b0, 1'b0, '0},
        '{8'h5A, 16'h3333, 1'b0, 1'b0, '0},
        '{8'hFF, 16'h0000, 1'b1, 1'b0, '0},
        // arrives in descending order
        '{8'hFF, 16'hA5A5, 1'b0, 1'b0, '0},
        '{8'h80, 16'h8000, 1'b0, 1'b0, '0},
        '{8'h7F, 16'h7FFF, 1'b0, 1'b0, '0},
        '{8'h01, 16'h0001, 1'b0, 1'b0, '0},
        '{8'h00, 16'h5A5A, 1'b1, 1'b0, '0},
        // digits at opposite ends, then one more lone record
        '{8'hF0, 16'hAAAA, 1'b0, 1'b0, '0},
        '{8'h0F, 16'h5555, 1'b1, 1'b0, '0},
        '{8'hA5, 16'h5AA5, 1'b1, 1'b1, '{8'hA5, 16'h5AA5, 1'b1, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bkrs_in_if  rec_ch ();
    bkrs_out_if res_ch ();

    byte_key_radix_sorter #(.MAX_RECORDS(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch),
        .o_res   (res_ch)
    );

    // Predictor state: records of the open set, drop flag, words still owed
    t_rec         held_recs [$];
    logic         held_dropped = 1'b0;
    t_sorted_word fresh_words [$];
    t_sorted_word awaited_words [$];

    int  mismatches = 0;
    int  words_checked = 0;
    int  sets_closed = 0;
    int  overflow_sets = 0;
    bit  calm = 1'b0;
    bit  held_off = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Store or drop one record; on last, stable sort the set by ascending key
    function automatic void absorb_record(t_rec r, logic is_last);
        t_sorted_word w;
        int           n;
        fresh_words.delete();
        if (held_recs.size() < CAPACITY)
            held_recs.push_back(r);
        else
            held_dropped = 1'b1;
        if (!is_last)
            return;
        n = held_recs.size();
        for (int v = 0; v < KEY_VALUES; v++) begin
            foreach (held_recs[i]) begin
                if (int'(held_recs[i].key) == v) begin
                    w.key = held_recs[i].key;
                    w.tag = held_recs[i].tag;
                    w.eos = (fresh_words.size() == n - 1);
                    w.ovf = held_dropped;
                    fresh_words.push_back(w);
                end
            end
        end
        sets_closed++;
        if (held_dropped)
            overflow_sets++;
        held_recs.delete();
        held_dropped = 1'b0;
    endfunction

    // Offer one record, wait for the handshake, then book what it causes
    task automatic offer_word(input t_rec r, input logic is_last, input logic typed,
                              input t_sorted_word want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 11) begin
            rec_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rec_ch.valid <= 1'b1;
        rec_ch.key   <= r.key;
        rec_ch.tag   <= r.tag;
        rec_ch.last  <= is_last;
        do @(posedge i_clk); while (!rec_ch.ready);
        absorb_record(r, is_last);
        if (typed) begin
            if (fresh_words.size() != 1)
                flag_mismatch("typed row does not close a one-record set");
            awaited_words.push_back(want);
        end else begin
            foreach (fresh_words[i])
                awaited_words.push_back(fresh_words[i]);
        end
    endtask

    // Result side: random ready, plus one long hold-off to back the block up
    initial begin : result_sink
        int hold_cycles;
        hold_cycles = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && words_checked >= 40) begin
                held_off = 1'b1;
                hold_cycles = 600;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    // Compare each accepted word with the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_sorted_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word key %02h tag %04h",
                                        res_ch.sorted_key, res_ch.sorted_tag));
            end else begin
                want = awaited_words.pop_front();
                words_checked++;
                if (res_ch.sorted_key !== want.key)
                    flag_mismatch($sformatf("word %0d sorted_key %02h, want %02h",
                                            words_checked, res_ch.sorted_key, want.key));
                if (res_ch.sorted_tag !== want.tag)
                    flag_mismatch($sformatf("word %0d sorted_tag %04h, want %04h",
                                            words_checked, res_ch.sorted_tag, want.tag));
                if (res_ch.end_of_set !== want.eos)
                    flag_mismatch($sformatf("word %0d end_of_set %b, want %b",
                                            words_checked, res_ch.end_of_set, want.eos));
                if (res_ch.overflow !== want.ovf)
                    flag_mismatch($sformatf("word %0d overflow %b, want %b",
                                            words_checked, res_ch.overflow, want.ovf));
            end
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #2000000;
        $display("byte_key_radix_sorter verification failed");
        $finish;
    end

    initial begin : stimulus
        t_rec           r;
        logic           is_last;
        int             sent;
        int             set_no;
        int             set_len;
        bit             narrow;
        logic [KEY_W-1:0] pool [4];

        rec_ch.valid = 1'b0;
        rec_ch.key   = '0;
        rec_ch.tag   = '0;
        rec_ch.last  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED[i]) begin
            r.key = DIRECTED[i].key;
            r.tag = DIRECTED[i].tag;
            offer_word(r, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Random sets: mostly small, one exactly full, one past capacity
        sent = 0;
        set_no = 0;
        while (sent < RANDOM_WORDS) begin
            case (set_no)
                2:       set_len = CAPACITY;
                5:       set_len = CAPACITY + 3;
                default: set_len = $urandom_range(12, 1);
            endcase
            // few distinct keys make ties, which shows up any loss of order
            narrow = 1'($urandom_range(1));
            foreach (pool[k])
                pool[k] = KEY_W'($urandom_range(KEY_VALUES - 1));
            for (int j = 0; j < set_len; j++) begin
                r.key = narrow ? pool[$urandom_range(3)]
                               : KEY_W'($urandom_range(KEY_VALUES - 1));
                r.tag = TAG_W'($urandom);
                is_last = (j == set_len - 1);
                calm = (sent >= 150 && sent < 190);
                offer_word(r, is_last, 1'b0, '0);
                sent++;
            end
            set_no++;
        end
        calm = 1'b0;
        @(negedge i_clk);
        rec_ch.valid <= 1'b0;

        while (awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sorted %0d sets, %0d with dropped records; %0d words checked.",
                 sets_closed, overflow_sets, words_checked);
        $display("Sets ran from one record to past capacity, with a long output stall.");
        if (mismatches == 0)
            $display("byte_key_radix_sorter verification clean");
        else
            $display("byte_key_radix_sorter verification failed");
        $finish;
    end

endmodule

[byte_key_radix_sorter.f]
hdl/bkrs_pkg.sv
hdl/bkrs_in_if.sv
hdl/bkrs_out_if.sv
hdl/bkrs_ram.sv
hdl/bkrs_datapath.sv
hdl/bkrs_ctrl.sv
hdl/byte_key_radix_sorter.sv
tb/byte_key_radix_sorter_test.sv
